>>> rtl/core/vcps_pkg.sv
`timescale 1ns / 1ps

package vcps_pkg;

    // Volume scale and field widths
    localparam int NUM_LEVELS = 4;
    localparam int LEVEL_W    = $clog2(NUM_LEVELS);
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 8;

    // Timing register reset values
    localparam logic [TICK_W-1:0] PULSE_TICKS_RST = TICK_W'(10);
    localparam logic [TICK_W-1:0] GAP_TICKS_RST   = TICK_W'(6);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_TICKS = CFG_IDX_W'(0),
        REG_GAP_TICKS   = CFG_IDX_W'(1)
    } cfg_reg_t;

    // Input word: one tick of requests
    typedef struct packed {
        logic       play_request;
        logic       item_request;
        logic       volume_request;
        logic [1:0] target_level;
    } in_word_t;

    // Output word: pin levels for one tick
    typedef struct packed {
        logic play_pin;
        logic item_pin;
        logic voice_pin;
        logic voice_busy;
    } out_word_t;

    // Status from the volume sequencer
    typedef struct packed {
        logic pin;
        logic busy;
        logic play_trigger;
    } voice_status_t;

endpackage

>>> rtl/core/vcps_pulse_unit.sv
`timescale 1ns / 1ps

module vcps_pulse_unit
    import vcps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              request,
    input  logic              force_start,
    input  logic [TICK_W-1:0] pulse_ticks,
    output logic              pin
);

    logic              active_reg, active_next;
    logic [TICK_W-1:0] timer_reg, timer_next;
    logic              act;
    logic [TICK_W-1:0] timer_inc;

    // One tick of the fixed-length pulse
    always_comb begin
        act         = active_reg | request;
        timer_inc   = timer_reg + TICK_W'(1);
        active_next = act;
        timer_next  = '0;
        pin         = act;
        if (act) begin
            if (timer_inc >= pulse_ticks) begin
                active_next = 1'b0;
            end else begin
                timer_next = timer_inc;
            end
        end
        // late start from the volume sequencer, pin rises next tick
        if (force_start) begin
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            timer_reg  <= '0;
        end else if (step_en) begin
            active_reg <= active_next;
            timer_reg  <= timer_next;
        end
    end

endmodule

>>> rtl/core/vcps_voice_seq.sv
`timescale 1ns / 1ps

module vcps_voice_seq
    import vcps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               volume_request,
    input  logic [1:0]         target_level,
    input  logic [TICK_W-1:0]  pulse_ticks,
    input  logic [TICK_W-1:0]  gap_ticks,
    output voice_status_t      status
);

    logic               active_reg, active_next;
    logic               init_reg, init_next;
    logic               low_reg, low_next;
    logic [TICK_W-1:0]  timer_reg, timer_next;
    logic [LEVEL_W-1:0] steps_reg, steps_next;
    logic [LEVEL_W-1:0] cur_reg, cur_next;
    logic [LEVEL_W-1:0] req_reg, req_next;
    logic               pin_reg, pin_next;
    logic               act, init;
    logic [TICK_W-1:0]  timer_inc;
    logic [LEVEL_W-1:0] steps_dec;
    logic               trig;

    // Volume step sequence: init tick, then high/low phases per step
    always_comb begin
        req_next    = volume_request ? LEVEL_W'(target_level % NUM_LEVELS) : req_reg;
        act         = active_reg | volume_request;
        init        = init_reg | volume_request;
        active_next = act;
        init_next   = init;
        low_next    = low_reg;
        timer_next  = timer_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        pin_next    = pin_reg;
        trig        = 1'b0;
        timer_inc   = timer_reg + TICK_W'(1);
        steps_dec   = (steps_reg != '0) ? steps_reg - LEVEL_W'(1) : steps_reg;
        if (act) begin
            if (init) begin
                init_next = 1'b0;
                if (req_next == cur_reg) begin
                    // already at level: play pulse instead
                    active_next = 1'b0;
                    trig        = 1'b1;
                    steps_next  = '0;
                end else begin
                    steps_next = req_next - cur_reg;
                end
                cur_next   = req_next;
                low_next   = 1'b0;
                timer_next = '0;
                pin_next   = 1'b0;
            end else if (!low_reg) begin
                pin_next = 1'b1;
                if (timer_inc >= pulse_ticks) begin
                    timer_next = '0;
                    low_next   = 1'b1;
                end else begin
                    timer_next = timer_inc;
                end
            end else begin
                pin_next = 1'b0;
                if (timer_inc >= gap_ticks) begin
                    timer_next = '0;
                    steps_next = steps_dec;
                    low_next   = 1'b0;
                    if (steps_dec == '0) begin
                        active_next = 1'b0;
                    end
                end else begin
                    timer_next = timer_inc;
                end
            end
        end
        status.pin          = pin_next;
        status.busy         = active_next;
        status.play_trigger = trig;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            init_reg   <= 1'b0;
            low_reg    <= 1'b0;
            timer_reg  <= '0;
            steps_reg  <= '0;
            cur_reg    <= '0;
            req_reg    <= '0;
            pin_reg    <= 1'b0;
        end else if (step_en) begin
            active_reg <= active_next;
            init_reg   <= init_next;
            low_reg    <= low_next;
            timer_reg  <= timer_next;
            steps_reg  <= steps_next;
            cur_reg    <= cur_next;
            req_reg    <= req_next;
            pin_reg    <= pin_next;
        end
    end

endmodule

>>> rtl/core/voice_chip_pulse_sequencer_top.sv
`timescale 1ns / 1ps
// Channel   Ports                           Word
// input     s_valid, s_ready, s_data        in_word_t: one tick of requests
// result    m_valid, m_ready, m_data        out_word_t: pin levels for that tick
// config    cfg_valid, cfg_ready, cfg_*     8-bit register write by index
//
// One word per cycle sustained while results are taken; each word passes the
// input register, then the tick update lands in the result register.
// Reset (aresetn low, synchronous) clears all sequencer state and loads the
// timing registers with their defaults. Config writes are always taken.
// A stalled result holds; one more word is held in the input register.

module voice_chip_pulse_sequencer_top
    import vcps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_wdata
);

    logic [TICK_W-1:0] pulse_ticks_reg;
    logic [TICK_W-1:0] gap_ticks_reg;
    logic              in_valid_reg;
    in_word_t          in_word_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;
    logic              advance;
    logic              play_pin, item_pin;
    voice_status_t     vstat;
    out_word_t         out_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ticks_reg <= PULSE_TICKS_RST;
            gap_ticks_reg   <= GAP_TICKS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PULSE_TICKS: pulse_ticks_reg <= cfg_wdata;
                REG_GAP_TICKS:   gap_ticks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: tick processed when input is held and result slot frees
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Play, item and voice units
    vcps_pulse_unit u_play (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .request     (in_word_reg.play_request),
        .force_start (vstat.play_trigger),
        .pulse_ticks (pulse_ticks_reg),
        .pin         (play_pin)
    );

    vcps_pulse_unit u_item (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .request     (in_word_reg.item_request),
        .force_start (1'b0),
        .pulse_ticks (pulse_ticks_reg),
        .pin         (item_pin)
    );

    vcps_voice_seq u_voice (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .volume_request (in_word_reg.volume_request),
        .target_level   (in_word_reg.target_level),
        .pulse_ticks    (pulse_ticks_reg),
        .gap_ticks      (gap_ticks_reg),
        .status         (vstat)
    );

    // Result register
    always_comb begin
        out_next.play_pin   = play_pin;
        out_next.item_pin   = item_pin;
        out_next.voice_pin  = vstat.pin;
        out_next.voice_busy = vstat.busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a result appears only after a held input word
    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result word without input word");

    // voice pin high only inside a running step sequence
    a_pin_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.voice_pin) |-> m_data_reg.voice_busy)
        else $error("voice pin high while sequencer idle");

    // both stages full and stalled: no new word taken
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full");
`endif

endmodule
